@@ rtl/assert_macros.svh @@
// Assertion macros used by the shade pipeline RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define HCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/hcs_pkg.sv @@
// Shared types and fixed-point constants of the HLS shade pipeline.
package hcs_pkg;

  typedef logic [15:0] chan_t;

  // Hue sector chosen by the largest channel.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Q1.16 unity and hue angles in Q.8 degrees.
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [16:0] HALF_Q16   = 17'd32768;
  localparam logic [16:0] SIXTH_TURN = 17'd15360;
  localparam logic [16:0] THIRD_TURN = 17'd30720;
  localparam logic [16:0] HALF_TURN  = 17'd46080;
  localparam logic [16:0] TWO_THIRDS = 17'd61440;
  localparam logic [16:0] FULL_TURN  = 17'd92160;

  // Reciprocal of 15 scaled by 2^26, rounded down.
  localparam logic [22:0] RECIP15 = 23'd4473924;

  // Quotient bits produced by each divider.
  localparam int QBITS = 17;

endpackage

@@ rtl/hcs_if.sv @@
// Valid/ready channels for the shade pipeline input and result words.
interface hcs_in_if
  import hcs_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  chan_t shade_factor;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output shade_factor, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input shade_factor, output ready);
endinterface

interface hcs_out_if
  import hcs_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

@@ rtl/hls_color_shade.sv @@
// HLS shade pipeline: RGB to HLS, scale lightness and saturation, back to RGB.
// Throughput: one word per cycle while the output is ready; two 17-stage restoring dividers set the depth.
// Each stage moves on when it is empty or its successor moves, so bubbles collapse.
// Reset (synchronous, rst_n low) clears all stage valid bits; payload is not reset.
`include "assert_macros.svh"

module hls_color_shade
  import hcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hcs_in_if.sink    in_chan,
  hcs_out_if.source out_chan
);

  localparam int ST_DIV0 = 2;
  localparam int ST_SC   = ST_DIV0 + QBITS + 1;
  localparam int ST_CM   = ST_SC + 1;
  localparam int ST_DM   = ST_CM + 1;
  localparam int ST_PR   = ST_DM + 1;
  localparam int ST_RC   = ST_PR + 1;
  localparam int ST_OUT  = ST_RC + 1;
  localparam int NSTG    = ST_OUT + 1;

  typedef struct packed {
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
    logic [15:0] k;
  } p1_t;

  typedef struct packed {
    logic [16:0] l;
    logic [16:0] d;
    logic [16:0] den;
    logic [16:0] hmag;
    logic        hneg;
    logic        grey;
    sector_t     sec;
    logic [15:0] k;
  } p2_t;

  typedef struct packed {
    logic [16:0] l;
    logic [16:0] d;
    logic [16:0] den;
    logic        hneg;
    logic        grey;
    sector_t     sec;
    logic [15:0] k;
    logic [32:0] srem;
    logic [32:0] hrem;
    logic [16:0] sq;
    logic [16:0] hq;
  } dv_t;

  typedef struct packed {
    logic [32:0] lk;
    logic [32:0] sk;
    logic [16:0] h;
  } sc_t;

  typedef struct packed {
    logic [34:0] p;
    logic [16:0] l;
    logic [16:0] s;
    logic        low;
    logic [16:0] xr;
    logic [16:0] xg;
    logic [16:0] xb;
  } cm_t;

  typedef struct packed {
    logic [16:0] m1;
    logic [16:0] dl;
    logic [13:0] tr;
    logic [13:0] tg;
    logic [13:0] tb;
  } dm_t;

  typedef struct packed {
    logic [16:0] m1;
    logic [30:0] pr;
    logic [30:0] pg;
    logic [30:0] pb;
  } pr_t;

  typedef struct packed {
    logic [16:0] m1;
    logic [20:0] vr;
    logic [20:0] vg;
    logic [20:0] vb;
    logic [43:0] er;
    logic [43:0] eg;
    logic [43:0] eb;
  } rc_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } res_t;

  // Map a 16-bit channel to Q1.16, full scale becomes exactly one.
  function automatic logic [16:0] chan_in(input logic [15:0] c);
    return (c == 16'hFFFF) ? ONE_Q16 : {1'b0, c};
  endfunction

  // One restoring step of both dividers at the given quotient bit.
  function automatic dv_t div_step(input dv_t a, input logic [4:0] bp);
    logic [33:0] ds;
    logic [33:0] dh;
    logic [33:0] ts;
    logic [33:0] th;
    dv_t         o;
    o  = a;
    ds = {17'b0, a.den} << bp;
    dh = {17'b0, a.d} << bp;
    ts = {1'b0, a.srem} - ds;
    th = {1'b0, a.hrem} - dh;
    if (!ts[33]) begin
      o.srem   = ts[32:0];
      o.sq[bp] = 1'b1;
    end
    if (!th[33]) begin
      o.hrem   = th[32:0];
      o.hq[bp] = 1'b1;
    end
    return o;
  endfunction

  // Ramp weight in sixths of a turn: rise, hold high, fall, hold low.
  function automatic logic [13:0] ramp_w(input logic [16:0] x);
    logic [16:0] f;
    logic [13:0] t;
    f = TWO_THIRDS - x;
    if (x < SIXTH_TURN) begin
      t = x[13:0];
    end else if (x < HALF_TURN) begin
      t = SIXTH_TURN[13:0];
    end else if (x < TWO_THIRDS) begin
      t = f[13:0];
    end else begin
      t = 14'd0;
    end
    return t;
  endfunction

  // Finish the divide by 15, add the ramp base and convert to 16 bits.
  function automatic chan_t finish(input logic [20:0] v, input logic [43:0] e,
                                   input logic [16:0] m1);
    logic [16:0] q;
    logic [20:0] rm;
    logic [16:0] qc;
    logic [17:0] val;
    logic [17:0] dec;
    q  = e[42:26];
    rm = v - ({4'b0, q} * 21'd15);
    qc = (rm >= 21'd15) ? q + 17'd1 : q;
    val = {1'b0, m1} + {1'b0, qc};
    if (val > {1'b0, ONE_Q16}) begin
      val = {1'b0, ONE_Q16};
    end
    dec = val - 18'd1;
    return (val == 18'd0) ? 16'd0 : dec[15:0];
  endfunction

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  p1_t  p1_r,  p1_nxt;
  p2_t  p2_r,  p2_nxt;
  dv_t  dv_r   [0:QBITS];
  dv_t  dv_nxt [0:QBITS];
  sc_t  sc_r,  sc_nxt;
  cm_t  cm_r,  cm_nxt;
  dm_t  dm_r,  dm_nxt;
  pr_t  pr_r,  pr_nxt;
  rc_t  rc_r,  rc_nxt;
  res_t out_r, out_nxt;

  // Advance a stage when it is empty or the next stage advances.
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_chan.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign vld_nxt      = {vld_r[NSTG-2:0], in_chan.valid};
  assign in_chan.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  // Expand channels to Q1.16.
  always_comb begin
    p1_nxt.r = chan_in(in_chan.red_in);
    p1_nxt.g = chan_in(in_chan.green_in);
    p1_nxt.b = chan_in(in_chan.blue_in);
    p1_nxt.k = in_chan.shade_factor;
  end

  // Find max and min, lightness, divisors and the hue difference.
  always_comb begin
    logic [16:0] mx;
    logic [16:0] mn;
    logic [17:0] sum;
    logic [17:0] diff;
    logic [17:0] ndiff;
    logic [17:0] rsum;
    if (p1_r.r > p1_r.g) begin
      mx = (p1_r.r > p1_r.b) ? p1_r.r : p1_r.b;
      mn = (p1_r.g < p1_r.b) ? p1_r.g : p1_r.b;
    end else begin
      mx = (p1_r.g > p1_r.b) ? p1_r.g : p1_r.b;
      mn = (p1_r.r < p1_r.b) ? p1_r.r : p1_r.b;
    end
    sum  = {1'b0, mx} + {1'b0, mn};
    rsum = 18'd131072 - sum;
    p2_nxt.l    = sum[17:1];
    p2_nxt.d    = mx - mn;
    p2_nxt.grey = (mx == mn);
    p2_nxt.den  = (sum <= {1'b0, ONE_Q16}) ? sum[16:0] : rsum[16:0];
    p2_nxt.k    = p1_r.k;
    priority if (p1_r.r == mx) begin
      p2_nxt.sec = SEC_RED;
      diff       = {1'b0, p1_r.g} - {1'b0, p1_r.b};
    end else if (p1_r.g == mx) begin
      p2_nxt.sec = SEC_GREEN;
      diff       = {1'b0, p1_r.b} - {1'b0, p1_r.r};
    end else begin
      p2_nxt.sec = SEC_BLUE;
      diff       = {1'b0, p1_r.r} - {1'b0, p1_r.g};
    end
    ndiff        = 18'd0 - diff;
    p2_nxt.hneg  = diff[17];
    p2_nxt.hmag  = diff[17] ? ndiff[16:0] : diff[16:0];
  end

  // Load both dividers and run one quotient bit per stage.
  always_comb begin
    dv_nxt[0].l    = p2_r.l;
    dv_nxt[0].d    = p2_r.d;
    dv_nxt[0].den  = p2_r.den;
    dv_nxt[0].hneg = p2_r.hneg;
    dv_nxt[0].grey = p2_r.grey;
    dv_nxt[0].sec  = p2_r.sec;
    dv_nxt[0].k    = p2_r.k;
    dv_nxt[0].srem = {p2_r.d, 16'b0};
    dv_nxt[0].hrem = {16'b0, p2_r.hmag} * {16'b0, SIXTH_TURN};
    dv_nxt[0].sq   = '0;
    dv_nxt[0].hq   = '0;
    for (int j = 0; j < QBITS; j++) begin
      dv_nxt[j+1] = div_step(dv_r[j], 5'(QBITS - 1 - j));
    end
  end

  // Scale lightness and saturation, place the hue in its sector.
  always_comb begin
    logic [16:0] s;
    logic [16:0] off;
    logic [18:0] hs;
    logic [18:0] hw;
    s = dv_r[QBITS].grey ? 17'd0 : dv_r[QBITS].sq;
    sc_nxt.lk = {16'b0, dv_r[QBITS].l} * {17'b0, dv_r[QBITS].k};
    sc_nxt.sk = {16'b0, s} * {17'b0, dv_r[QBITS].k};
    unique case (dv_r[QBITS].sec)
      SEC_RED:   off = 17'd0;
      SEC_GREEN: off = THIRD_TURN;
      SEC_BLUE:  off = TWO_THIRDS;
      default:   off = 17'd0;
    endcase
    hs = dv_r[QBITS].hneg ? {2'b0, off} - {2'b0, dv_r[QBITS].hq}
                          : {2'b0, off} + {2'b0, dv_r[QBITS].hq};
    hw = hs[18] ? hs + {2'b0, FULL_TURN} : hs;
    sc_nxt.h = dv_r[QBITS].grey ? 17'd0 : hw[16:0];
  end

  // Clamp scaled values, start m2 product, rotate hue per channel.
  always_comb begin
    logic [16:0] lc;
    logic [16:0] scl;
    logic [17:0] op;
    logic [17:0] hp;
    logic [17:0] hpw;
    logic [16:0] hm;
    lc  = (sc_r.lk[32:12] > {4'b0, ONE_Q16}) ? ONE_Q16 : sc_r.lk[28:12];
    scl = (sc_r.sk[32:12] > {4'b0, ONE_Q16}) ? ONE_Q16 : sc_r.sk[28:12];
    cm_nxt.l   = lc;
    cm_nxt.s   = scl;
    cm_nxt.low = (lc <= HALF_Q16);
    op = (lc <= HALF_Q16) ? {1'b0, ONE_Q16} + {1'b0, scl} : {1'b0, scl};
    cm_nxt.p = {18'b0, lc} * {17'b0, op};
    hp  = {1'b0, sc_r.h} + {1'b0, THIRD_TURN};
    hpw = hp - {1'b0, FULL_TURN};
    cm_nxt.xr = (hp >= {1'b0, FULL_TURN}) ? hpw[16:0] : hp[16:0];
    cm_nxt.xg = sc_r.h;
    hm = sc_r.h - THIRD_TURN;
    cm_nxt.xb = (sc_r.h >= THIRD_TURN) ? hm : sc_r.h + TWO_THIRDS;
  end

  // Form m1 and m2, pick ramp weights.
  always_comb begin
    logic [17:0] ls;
    logic [17:0] hi;
    logic [16:0] m2;
    logic [17:0] m1w;
    ls  = {1'b0, cm_r.l} + {1'b0, cm_r.s};
    hi  = ls - cm_r.p[33:16];
    m2  = cm_r.low ? cm_r.p[32:16] : hi[16:0];
    m1w = {cm_r.l, 1'b0} - {1'b0, m2};
    dm_nxt.m1 = m1w[16:0];
    dm_nxt.dl = m2 - m1w[16:0];
    dm_nxt.tr = ramp_w(cm_r.xr);
    dm_nxt.tg = ramp_w(cm_r.xg);
    dm_nxt.tb = ramp_w(cm_r.xb);
  end

  // Multiply the ramp span by each weight.
  always_comb begin
    pr_nxt.m1 = dm_r.m1;
    pr_nxt.pr = {14'b0, dm_r.dl} * {17'b0, dm_r.tr};
    pr_nxt.pg = {14'b0, dm_r.dl} * {17'b0, dm_r.tg};
    pr_nxt.pb = {14'b0, dm_r.dl} * {17'b0, dm_r.tb};
  end

  // Drop the factor 1024 and multiply by the reciprocal of 15.
  always_comb begin
    rc_nxt.m1 = pr_r.m1;
    rc_nxt.vr = pr_r.pr[30:10];
    rc_nxt.vg = pr_r.pg[30:10];
    rc_nxt.vb = pr_r.pb[30:10];
    rc_nxt.er = {23'b0, pr_r.pr[30:10]} * {21'b0, RECIP15};
    rc_nxt.eg = {23'b0, pr_r.pg[30:10]} * {21'b0, RECIP15};
    rc_nxt.eb = {23'b0, pr_r.pb[30:10]} * {21'b0, RECIP15};
  end

  // Correct the quotient and build the output word.
  always_comb begin
    out_nxt.red   = finish(rc_r.vr, rc_r.er, rc_r.m1);
    out_nxt.green = finish(rc_r.vg, rc_r.eg, rc_r.m1);
    out_nxt.blue  = finish(rc_r.vb, rc_r.eb, rc_r.m1);
  end

  // Hold payload while a stage stalls.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p1_r <= p1_nxt;
    end
    if (adv[1]) begin
      p2_r <= p2_nxt;
    end
    for (int j = 0; j <= QBITS; j++) begin
      if (adv[ST_DIV0 + j]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
    if (adv[ST_SC]) begin
      sc_r <= sc_nxt;
    end
    if (adv[ST_CM]) begin
      cm_r <= cm_nxt;
    end
    if (adv[ST_DM]) begin
      dm_r <= dm_nxt;
    end
    if (adv[ST_PR]) begin
      pr_r <= pr_nxt;
    end
    if (adv[ST_RC]) begin
      rc_r <= rc_nxt;
    end
    if (adv[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid     = vld_r[ST_OUT];
  assign out_chan.red_out   = out_r.red;
  assign out_chan.green_out = out_r.green;
  assign out_chan.blue_out  = out_r.blue;

  `HCS_ASSERT(a_div_nonzero,
              vld_r[ST_DIV0] && !dv_r[0].grey |-> dv_r[0].den != 17'd0 && dv_r[0].d != 17'd0,
              "zero divisor on a colored word")
  `HCS_ASSERT(a_quot_range,
              vld_r[ST_SC - 1] && !dv_r[QBITS].grey |->
                dv_r[QBITS].sq <= ONE_Q16 && dv_r[QBITS].hq <= SIXTH_TURN,
              "divider quotient out of range")
  `HCS_ASSERT(a_ramp_span,
              (vld_r[ST_DM] |-> ({1'b0, dm_r.m1} + {1'b0, dm_r.dl} <= {1'b0, ONE_Q16})),
              "ramp top above one")
  `HCS_ASSERT_RST(a_reset_clear, !rst_n |=> vld_r == '0,
                  "stage valid bits not cleared by reset")

endmodule

@@ bench/tb_top.sv @@
// Testbench for hls_color_shade: directed table plus random colors, checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
  import hcs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hcs_in_if  in_chan ();
  hcs_out_if out_chan ();

  hls_color_shade dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  typedef struct {
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t k;
    bit    known;
    rgb_t  res;
  } shade_row_t;

  rgb_t shade_q[$];
  int   fail_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_recv = 1'b0;
  int   sent_cnt = 0;

  // Map one Q1.16 channel value back to 16 bits.
  function automatic chan_t to_chan(longint v);
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    return chan_t'((v * 65535) >> 16);
  endfunction

  function automatic longint scale_q16(longint v, longint k);
    longint t;
    t = (v * k) >>> 12;
    return (t > 65536) ? 65536 : t;
  endfunction

  function automatic longint hue_wrap(longint x);
    if (x >= 92160) x -= 92160;
    if (x < 0) x += 92160;
    return x;
  endfunction

  function automatic longint hue_ramp(longint m1, longint m2, longint x);
    if (x < 15360) return m1 + ((m2 - m1) * x) / 15360;
    if (x < 46080) return m2;
    if (x < 61440) return m1 + ((m2 - m1) * (61440 - x)) / 15360;
    return m1;
  endfunction

  // Convert to HLS, scale lightness and saturation, convert back.
  function automatic rgb_t shade_color(chan_t ri, chan_t gi, chan_t bi, chan_t ki);
    longint r, g, b, mx, mn, sum, l, s, h, d, m1, m2;
    rgb_t o;
    r = (ri == 16'hFFFF) ? 65536 : ri;
    g = (gi == 16'hFFFF) ? 65536 : gi;
    b = (bi == 16'hFFFF) ? 65536 : bi;
    s = 0;
    h = 0;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    sum = mx + mn;
    l = sum >>> 1;
    if (mx != mn) begin
      d = mx - mn;
      s = (sum <= 65536) ? (d * 65536) / sum : (d * 65536) / (131072 - sum);
      if (r == mx) h = (15360 * (g - b)) / d;
      else if (g == mx) h = 30720 + (15360 * (b - r)) / d;
      else h = 61440 + (15360 * (r - g)) / d;
      if (h < 0) h += 92160;
    end
    l = scale_q16(l, ki);
    s = scale_q16(s, ki);
    if (s == 0) begin
      o.r = to_chan(l);
      o.g = o.r;
      o.b = o.r;
      return o;
    end
    m2 = (l <= 32768) ? (l * (65536 + s)) >>> 16 : l + s - ((l * s) >>> 16);
    m1 = 2 * l - m2;
    o.r = to_chan(hue_ramp(m1, m2, hue_wrap(h + 30720)));
    o.g = to_chan(hue_ramp(m1, m2, hue_wrap(h)));
    o.b = to_chan(hue_ramp(m1, m2, hue_wrap(h - 30720)));
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  // Offer one word, then hold it until accepted.
  task automatic send_word(chan_t r, chan_t g, chan_t b, chan_t k);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.red_in <= r;
    in_chan.green_in <= g;
    in_chan.blue_in <= b;
    in_chan.shade_factor <= k;
    shade_q.push_back(shade_color(r, g, b, k));
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic drain_wait();
    in_chan.valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
  endtask

  function automatic chan_t rand_chan();
    case ($urandom_range(5, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(32768 + $urandom_range(3, 0) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic chan_t rand_factor();
    case ($urandom_range(7, 0))
      0: return 16'd0;
      1: return 16'd4096;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return 16'($urandom_range(8191, 0));
    endcase
  endfunction

  // Receiver: stall at random, check each accepted word against the oldest prediction.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (shade_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = shade_q.pop_front();
        if (out_chan.red_out !== want.r) report_mismatch("red", out_chan.red_out, want.r);
        if (out_chan.green_out !== want.g)
          report_mismatch("green", out_chan.green_out, want.g);
        if (out_chan.blue_out !== want.b) report_mismatch("blue", out_chan.blue_out, want.b);
      end
    end
    out_chan.ready <= !hold_recv &&
                      !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // Long receiver hold-off so the pipeline fills and backs up the input.
  initial begin
    int n;
    wait (sent_cnt >= 300);
    @(posedge clk);
    hold_recv <= 1'b1;
    for (n = 0; n < 200; n++) @(posedge clk);
    hold_recv <= 1'b0;
  end

  initial begin
    #50ms;
    $display("** hls_color_shade: FAILED **");
    $finish;
  end

  initial begin
    shade_row_t rows[$];
    rgb_t got_exp;
    int phase, n;
    in_chan.valid = 1'b0;
    in_chan.red_in = '0;
    in_chan.green_in = '0;
    in_chan.blue_in = '0;
    in_chan.shade_factor = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, grey inputs, each hue sector, factor edges.
    rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'd4096, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4096, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
      '{16'hFFFF, 16'h0000, 16'h0000, 16'd0, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF}},
      '{16'h8000, 16'h8000, 16'h8000, 16'd4096, 0, '{0, 0, 0}},
      '{16'hFFFF, 16'h0000, 16'h0000, 16'd4096, 0, '{0, 0, 0}},
      '{16'h0000, 16'hFFFF, 16'h0000, 16'd4096, 0, '{0, 0, 0}},
      '{16'h0000, 16'h0000, 16'hFFFF, 16'd4096, 0, '{0, 0, 0}},
      '{16'hFFFF, 16'h0000, 16'h0001, 16'd4096, 0, '{0, 0, 0}},
      '{16'hFFFF, 16'h0000, 16'hFFFE, 16'd4096, 0, '{0, 0, 0}},
      '{16'hFFFF, 16'hFFFF, 16'h0000, 16'd4096, 0, '{0, 0, 0}},
      '{16'h4000, 16'hC000, 16'h8000, 16'd2048, 0, '{0, 0, 0}},
      '{16'h4000, 16'h8000, 16'hC000, 16'd8192, 0, '{0, 0, 0}},
      '{16'hC000, 16'h4000, 16'h8000, 16'hFFFF, 0, '{0, 0, 0}},
      '{16'h1234, 16'h5678, 16'h9ABC, 16'h5555, 0, '{0, 0, 0}},
      '{16'hAAAA, 16'h5555, 16'h0F0F, 16'hAAAA, 0, '{0, 0, 0}},
      '{16'h7FFF, 16'h8000, 16'h8001, 16'd4096, 0, '{0, 0, 0}},
      '{16'h0001, 16'h0000, 16'h0000, 16'd1, 0, '{0, 0, 0}}
    };
    foreach (rows[i]) begin
      if (rows[i].known) begin
        got_exp = shade_color(rows[i].r, rows[i].g, rows[i].b, rows[i].k);
        if (got_exp !== rows[i].res) report_mismatch("table row", i, 0);
      end
      send_word(rows[i].r, rows[i].g, rows[i].b, rows[i].k);
    end
    drain_wait();

    // Random phases: free flow, sender idle, receiver stall, both.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 21 : 0;
      recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 21 : 0;
      for (n = 0; n < 383; n++) begin
        if (n % 97 == 50) begin
          send_idle_pct = 0;
        end else if (n % 97 == 80) begin
          send_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 21 : 0;
        end
        send_word(rand_chan(), rand_chan(), rand_chan(), rand_factor());
      end
      // Sender pauses until every prediction has been checked against a result.
      drain_wait();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_wait();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && shade_q.size() == 0) begin
      $display("** hls_color_shade: PASSED **");
    end else begin
      $display("** hls_color_shade: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/hcs_pkg.sv
rtl/hcs_if.sv
rtl/hls_color_shade.sv
bench/tb_top.sv
